/* rtl/sdrd_pkg.sv */
// Shared types, constants and helper functions for the SD card SPI block read engine.
// Used by every module of the engine; depends on nothing else.

package sdrd_pkg;

   localparam int BLOCK_BYTES = 512;
   localparam int CRC_BYTES   = 2;
   localparam int FRAME_BYTES = 8;

   localparam logic [7:0] FILL_BYTE   = 8'hFF;
   localparam logic [7:0] DATA_TOKEN  = 8'hFE;
   localparam logic [7:0] CMD17_BYTE  = 8'h51;
   localparam logic [7:0] DUMMY_CRC   = 8'h01;

   typedef enum logic {
      OP_START    = 1'b0,
      OP_EXCHANGE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_BUSY   = 2'd0,
      ST_OK     = 2'd1,
      ST_PARERR = 2'd2,
      ST_ERROR  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_FRAME = 4'd1,
      PH_RESP  = 4'd2,
      PH_TOKEN = 4'd3,
      PH_DATA  = 4'd4
   } phase_type;

   typedef enum logic [1:0] {
      REG_LAST_SECTOR = 2'd0,
      REG_RESP_LIMIT  = 2'd1,
      REG_TOKEN_LIMIT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [31:0] last_sector_index;
      logic [15:0] response_poll_limit;
      logic [15:0] token_poll_limit;
   } config_type;

   typedef struct packed {
      phase_type   phase;
      logic [9:0]  frame_or_byte_count;
      logic [15:0] poll_count;
      logic [31:0] byte_address;
      logic [9:0]  saved_offset;
      logic [9:0]  saved_count;
      logic [9:0]  delivered_count;
   } engine_state_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        chip_select_active;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [9:0]  data_index;
      logic        done_res;
      status_type  status_code;
   } result_type;

   // Byte number idx of the CMD17 command frame, deselect byte first.
   function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [31:0] addr);
      logic [7:0] b;
      case (idx)
         3'd0:    b = FILL_BYTE;
         3'd1:    b = FILL_BYTE;
         3'd2:    b = CMD17_BYTE;
         3'd3:    b = addr[31:24];
         3'd4:    b = addr[23:16];
         3'd5:    b = addr[15:8];
         3'd6:    b = addr[7:0];
         default: b = DUMMY_CRC;
      endcase
      return b;
   endfunction

endpackage

/* rtl/sdrd_step.sv */
// Next-state and result logic of the block read engine for one item.
// Purely combinational; uses types and constants from sdrd_pkg.

module sdrd_step (
   input  sdrd_pkg::engine_state_type state,
   input  sdrd_pkg::config_type       cfg,
   input  logic                       opcode,
   input  logic [31:0]                sector_number,
   input  logic [9:0]                 window_offset,
   input  logic [9:0]                 window_count,
   input  logic [7:0]                 rx_byte,
   output sdrd_pkg::engine_state_type step_state,
   output sdrd_pkg::result_type       result
);

   logic [16:0] poll_inc;
   logic [10:0] window_end;
   logic [10:0] pos_ext;
   logic        in_window;
   logic        last_byte;

   assign poll_inc   = {1'b0, state.poll_count} + 17'd1;
   assign window_end = {1'b0, state.saved_offset} + {1'b0, state.saved_count};
   assign pos_ext    = {1'b0, state.frame_or_byte_count};
   assign in_window  = (pos_ext < 11'(sdrd_pkg::BLOCK_BYTES)) &&
                       (state.frame_or_byte_count >= state.saved_offset) &&
                       (pos_ext < window_end);
   // The transfer ends after the last CRC byte has been clocked in.
   assign last_byte  = (pos_ext >= 11'(sdrd_pkg::BLOCK_BYTES + sdrd_pkg::CRC_BYTES - 1));

   always_comb begin
      step_state = state;
      result     = '0;
      if (opcode == sdrd_pkg::OP_START) begin
         // A start that arrives during a transfer is dropped.
         if (state.phase == sdrd_pkg::PH_IDLE) begin
            if ((sector_number > cfg.last_sector_index) || (window_count == 10'd0)) begin
               result.done_res    = 1'b1;
               result.status_code = sdrd_pkg::ST_PARERR;
            end else begin
               step_state.byte_address        = {sector_number[22:0], 9'd0};
               step_state.saved_offset        = window_offset;
               step_state.saved_count         = window_count;
               step_state.delivered_count     = 10'd0;
               step_state.poll_count          = 16'd0;
               step_state.phase               = sdrd_pkg::PH_FRAME;
               step_state.frame_or_byte_count = 10'd1;
               result.tx_valid                = 1'b1;
               result.tx_byte                 = sdrd_pkg::FILL_BYTE;
               result.chip_select_active      = 1'b0;
            end
         end
      end else begin
         case (state.phase)
            sdrd_pkg::PH_IDLE: begin
            end
            sdrd_pkg::PH_FRAME: begin
               result.tx_valid           = 1'b1;
               result.chip_select_active = 1'b1;
               if (state.frame_or_byte_count < 10'(sdrd_pkg::FRAME_BYTES)) begin
                  result.tx_byte = sdrd_pkg::frame_byte(state.frame_or_byte_count[2:0],
                                                        state.byte_address);
                  result.chip_select_active = (state.frame_or_byte_count != 10'd0);
                  step_state.frame_or_byte_count = state.frame_or_byte_count + 10'd1;
               end else begin
                  result.tx_byte        = sdrd_pkg::FILL_BYTE;
                  step_state.phase      = sdrd_pkg::PH_RESP;
                  step_state.poll_count = 16'd0;
               end
            end
            sdrd_pkg::PH_RESP: begin
               if (!rx_byte[7]) begin
                  if (rx_byte == 8'd0) begin
                     step_state.phase          = sdrd_pkg::PH_TOKEN;
                     step_state.poll_count     = 16'd0;
                     result.tx_valid           = 1'b1;
                     result.tx_byte            = sdrd_pkg::FILL_BYTE;
                     result.chip_select_active = 1'b1;
                  end else begin
                     step_state.phase   = sdrd_pkg::PH_IDLE;
                     result.done_res    = 1'b1;
                     result.status_code = sdrd_pkg::ST_ERROR;
                  end
               end else begin
                  step_state.poll_count = poll_inc[15:0];
                  if (poll_inc >= {1'b0, cfg.response_poll_limit}) begin
                     step_state.phase   = sdrd_pkg::PH_IDLE;
                     result.done_res    = 1'b1;
                     result.status_code = sdrd_pkg::ST_ERROR;
                  end else begin
                     result.tx_valid           = 1'b1;
                     result.tx_byte            = sdrd_pkg::FILL_BYTE;
                     result.chip_select_active = 1'b1;
                  end
               end
            end
            sdrd_pkg::PH_TOKEN: begin
               if (rx_byte == sdrd_pkg::DATA_TOKEN) begin
                  step_state.phase               = sdrd_pkg::PH_DATA;
                  step_state.frame_or_byte_count = 10'd0;
                  step_state.delivered_count     = 10'd0;
                  result.tx_valid                = 1'b1;
                  result.tx_byte                 = sdrd_pkg::FILL_BYTE;
                  result.chip_select_active      = 1'b1;
               end else if (rx_byte != sdrd_pkg::FILL_BYTE) begin
                  step_state.phase   = sdrd_pkg::PH_IDLE;
                  result.done_res    = 1'b1;
                  result.status_code = sdrd_pkg::ST_ERROR;
               end else begin
                  step_state.poll_count = poll_inc[15:0];
                  if (poll_inc >= {1'b0, cfg.token_poll_limit}) begin
                     step_state.phase   = sdrd_pkg::PH_IDLE;
                     result.done_res    = 1'b1;
                     result.status_code = sdrd_pkg::ST_ERROR;
                  end else begin
                     result.tx_valid           = 1'b1;
                     result.tx_byte            = sdrd_pkg::FILL_BYTE;
                     result.chip_select_active = 1'b1;
                  end
               end
            end
            sdrd_pkg::PH_DATA: begin
               if (in_window) begin
                  result.data_valid          = 1'b1;
                  result.data_byte           = rx_byte;
                  result.data_index          = state.delivered_count;
                  step_state.delivered_count = state.delivered_count + 10'd1;
               end
               if (last_byte) begin
                  step_state.phase   = sdrd_pkg::PH_IDLE;
                  result.done_res    = 1'b1;
                  result.status_code = sdrd_pkg::ST_OK;
               end else begin
                  step_state.frame_or_byte_count = state.frame_or_byte_count + 10'd1;
                  result.tx_valid                = 1'b1;
                  result.tx_byte                 = sdrd_pkg::FILL_BYTE;
                  result.chip_select_active      = 1'b1;
               end
            end
            default: begin
               step_state.phase = sdrd_pkg::PH_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/sdrd_rsp_reg.sv */
// Result register of the block read engine with valid/stall handshake.
// Uses result_type from sdrd_pkg.

module sdrd_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  sdrd_pkg::result_type load_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output sdrd_pkg::result_type rsp_data,
   output logic                 full_stalled
);

   logic                 valid_ff;
   logic                 valid_in;
   sdrd_pkg::result_type data_ff;

   // The register can take a new item when it is empty or its item leaves now.
   assign full_stalled = valid_ff && rsp_stall;
   assign valid_in     = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* rtl/sd_spi_block_read_engine.sv */
// Top level of the SD card SPI-mode single block read (CMD17) engine.
// Depends on sdrd_pkg, sdrd_step and sdrd_rsp_reg.
//
// Each item is either a start request or the report of one finished SPI byte
// exchange; each gives exactly one result that names the next byte to shift
// out, an optional delivered window byte, and the end status. An item is
// handled in the cycle it is accepted and its result sits in the output
// register from the next cycle on, so one item per clock is taken as long as
// the result side does not stall; req_stall only follows a stalled, full
// output register. Configuration registers are written through the csr_ port
// by the user, only while the engine is idle; the block does not enforce this.

module sd_spi_block_read_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_sector_number,
   input  logic [9:0]  req_window_offset,
   input  logic [9:0]  req_window_count,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_chip_select_active,
   output logic        rsp_data_valid,
   output logic [7:0]  rsp_data_byte,
   output logic [9:0]  rsp_data_index,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status_code
);

   sdrd_pkg::config_type       cfg_ff;
   sdrd_pkg::engine_state_type state_ff;
   sdrd_pkg::engine_state_type state_in;
   sdrd_pkg::result_type       step_result;
   sdrd_pkg::result_type       rsp_data;
   logic                       accept;
   logic                       full_stalled;

   assign req_stall = full_stalled;
   assign accept    = req_valid && !full_stalled;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.last_sector_index   <= 32'd0;
         cfg_ff.response_poll_limit <= 16'd16;
         cfg_ff.token_poll_limit    <= 16'd4096;
      end else if (csr_write_enable) begin
         case (csr_index)
            sdrd_pkg::REG_LAST_SECTOR: cfg_ff.last_sector_index   <= csr_write_data;
            sdrd_pkg::REG_RESP_LIMIT:  cfg_ff.response_poll_limit <= csr_write_data[15:0];
            sdrd_pkg::REG_TOKEN_LIMIT: cfg_ff.token_poll_limit    <= csr_write_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: sdrd_pkg::PH_IDLE, default: '0};
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   sdrd_step u_step (
      .state         (state_ff),
      .cfg           (cfg_ff),
      .opcode        (req_opcode),
      .sector_number (req_sector_number),
      .window_offset (req_window_offset),
      .window_count  (req_window_count),
      .rx_byte       (req_rx_byte),
      .step_state    (state_in),
      .result        (step_result)
   );

   sdrd_rsp_reg u_rsp_reg (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .load_data    (step_result),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .full_stalled (full_stalled)
   );

   assign rsp_tx_valid           = rsp_data.tx_valid;
   assign rsp_tx_byte            = rsp_data.tx_byte;
   assign rsp_chip_select_active = rsp_data.chip_select_active;
   assign rsp_data_valid         = rsp_data.data_valid;
   assign rsp_data_byte          = rsp_data.data_byte;
   assign rsp_data_index         = rsp_data.data_index;
   assign rsp_done_res           = rsp_data.done_res;
   assign rsp_status_code        = rsp_data.status_code;

endmodule

/* sim/testbench.sv */
// Testbench for sd_spi_block_read_engine: directed items from a table, then random CMD17 reads.
// Depends on sdrd_pkg and the engine RTL; every result is checked against a local predictor or a fixed table result.

module testbench;

   localparam int unsigned CYCLE_LIMIT = 200000;

   typedef struct packed {
      sdrd_pkg::opcode_type opcode;
      logic [31:0]          sector;
      logic [9:0]           offset;
      logic [9:0]           count;
      logic [7:0]           rx;
   } read_req_type;

   typedef struct packed {
      read_req_type         req;
      logic                 has_fixed;
      sdrd_pkg::result_type result;
   } directed_row_type;

   typedef enum int {
      XFER_BAD_START,
      XFER_R1_ERROR,
      XFER_R1_TIMEOUT,
      XFER_TOKEN_ERROR,
      XFER_TOKEN_TIMEOUT,
      XFER_FULL_READ
   } xfer_kind_type;

   localparam sdrd_pkg::result_type NULL_RESULT = '0;
   localparam sdrd_pkg::result_type PARAM_ERROR_RESULT =
      '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 10'd0, 1'b1, sdrd_pkg::ST_PARERR};
   localparam sdrd_pkg::result_type CARD_ERROR_RESULT =
      '{1'b0, 8'h00, 1'b0, 1'b0, 8'h00, 10'd0, 1'b1, sdrd_pkg::ST_ERROR};
   localparam sdrd_pkg::result_type FIRST_BYTE_RESULT =
      '{1'b1, sdrd_pkg::FILL_BYTE, 1'b0, 1'b0, 8'h00, 10'd0, 1'b0, sdrd_pkg::ST_BUSY};

   // Reset configuration applies here: last sector 0, R1 limit 16.
   localparam directed_row_type DIRECTED_ROWS [17] = '{
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'hFF}, 1'b1, NULL_RESULT},
      '{'{sdrd_pkg::OP_START, 32'h1, 10'd0, 10'd1, 8'h00}, 1'b1, PARAM_ERROR_RESULT},
      '{'{sdrd_pkg::OP_START, 32'h0, 10'd1023, 10'd0, 8'hFF}, 1'b1, PARAM_ERROR_RESULT},
      '{'{sdrd_pkg::OP_START, 32'h0, 10'd0, 10'd1023, 8'h00}, 1'b1, FIRST_BYTE_RESULT},
      '{'{sdrd_pkg::OP_START, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 8'hFF}, 1'b1, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'h00}, 1'b0, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'hFF}, 1'b0, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'h80}, 1'b0, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'h7F}, 1'b0, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'h01}, 1'b0, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'hFE}, 1'b0, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'h55}, 1'b0, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'hAA}, 1'b0, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'h80}, 1'b0, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'hFF}, 1'b0, NULL_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'h01}, 1'b1, CARD_ERROR_RESULT},
      '{'{sdrd_pkg::OP_EXCHANGE, 32'h0, 10'd0, 10'd0, 8'h00}, 1'b1, NULL_RESULT}
   };

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [31:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [31:0] req_sector_number;
   logic [9:0]  req_window_offset;
   logic [9:0]  req_window_count;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_chip_select_active;
   logic        rsp_data_valid;
   logic [7:0]  rsp_data_byte;
   logic [9:0]  rsp_data_index;
   logic        rsp_done_res;
   logic [1:0]  rsp_status_code;

   // Predictor copy of the configuration and of the engine state.
   logic [31:0]         cfg_last_sector;
   logic [15:0]         cfg_resp_limit;
   logic [15:0]         cfg_token_limit;
   sdrd_pkg::phase_type eng_phase;
   logic [9:0]          eng_pos;
   int unsigned         eng_polls;
   logic [31:0]         eng_address;
   logic [9:0]          eng_offset;
   logic [9:0]          eng_count;
   logic [9:0]          eng_delivered;

   sdrd_pkg::result_type exchange_results_due[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   bit          idle_off = 1'b0;

   sd_spi_block_read_engine u_top (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_sector_number(req_sector_number),
      .req_window_offset(req_window_offset),
      .req_window_count(req_window_count),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_chip_select_active(rsp_chip_select_active),
      .rsp_data_valid(rsp_data_valid),
      .rsp_data_byte(rsp_data_byte),
      .rsp_data_index(rsp_data_index),
      .rsp_done_res(rsp_done_res),
      .rsp_status_code(rsp_status_code)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic sdrd_pkg::result_type shift_out(input logic [7:0] b, input logic cs);
      sdrd_pkg::result_type o;
      o = '0;
      o.tx_valid = 1'b1;
      o.tx_byte = b;
      o.chip_select_active = cs;
      return o;
   endfunction

   function automatic sdrd_pkg::result_type release_card(input sdrd_pkg::status_type s);
      sdrd_pkg::result_type o;
      o = '0;
      o.done_res = 1'b1;
      o.status_code = s;
      eng_phase = sdrd_pkg::PH_IDLE;
      return o;
   endfunction

   // Works out the result of one accepted item and advances the predicted engine.
   function automatic sdrd_pkg::result_type advance_read_engine(input read_req_type r);
      sdrd_pkg::result_type o;
      logic [9:0] pos;
      o = '0;
      if (r.opcode == sdrd_pkg::OP_START) begin
         if (eng_phase != sdrd_pkg::PH_IDLE) return o;
         if (r.sector > cfg_last_sector || r.count == 10'd0)
            return release_card(sdrd_pkg::ST_PARERR);
         eng_address = r.sector << 9;
         eng_offset = r.offset;
         eng_count = r.count;
         eng_delivered = '0;
         eng_polls = 0;
         eng_phase = sdrd_pkg::PH_FRAME;
         eng_pos = 10'd1;
         return shift_out(sdrd_pkg::FILL_BYTE, 1'b0);
      end
      case (eng_phase)
         sdrd_pkg::PH_FRAME: begin
            if (eng_pos < sdrd_pkg::FRAME_BYTES) begin
               case (eng_pos)
                  10'd1: o = shift_out(sdrd_pkg::FILL_BYTE, 1'b1);
                  10'd2: o = shift_out(sdrd_pkg::CMD17_BYTE, 1'b1);
                  10'd3: o = shift_out(eng_address[31:24], 1'b1);
                  10'd4: o = shift_out(eng_address[23:16], 1'b1);
                  10'd5: o = shift_out(eng_address[15:8], 1'b1);
                  10'd6: o = shift_out(eng_address[7:0], 1'b1);
                  default: o = shift_out(sdrd_pkg::DUMMY_CRC, 1'b1);
               endcase
               eng_pos = eng_pos + 10'd1;
            end else begin
               eng_phase = sdrd_pkg::PH_RESP;
               eng_polls = 0;
               o = shift_out(sdrd_pkg::FILL_BYTE, 1'b1);
            end
         end
         sdrd_pkg::PH_RESP: begin
            if (!r.rx[7]) begin
               if (r.rx == 8'h00) begin
                  eng_phase = sdrd_pkg::PH_TOKEN;
                  eng_polls = 0;
                  o = shift_out(sdrd_pkg::FILL_BYTE, 1'b1);
               end else begin
                  o = release_card(sdrd_pkg::ST_ERROR);
               end
            end else begin
               eng_polls++;
               if (eng_polls >= cfg_resp_limit) o = release_card(sdrd_pkg::ST_ERROR);
               else o = shift_out(sdrd_pkg::FILL_BYTE, 1'b1);
            end
         end
         sdrd_pkg::PH_TOKEN: begin
            if (r.rx == sdrd_pkg::DATA_TOKEN) begin
               eng_phase = sdrd_pkg::PH_DATA;
               eng_pos = '0;
               eng_delivered = '0;
               o = shift_out(sdrd_pkg::FILL_BYTE, 1'b1);
            end else if (r.rx != sdrd_pkg::FILL_BYTE) begin
               o = release_card(sdrd_pkg::ST_ERROR);
            end else begin
               eng_polls++;
               if (eng_polls >= cfg_token_limit) o = release_card(sdrd_pkg::ST_ERROR);
               else o = shift_out(sdrd_pkg::FILL_BYTE, 1'b1);
            end
         end
         sdrd_pkg::PH_DATA: begin
            pos = eng_pos;
            if (int'(pos) + 1 >= sdrd_pkg::BLOCK_BYTES + sdrd_pkg::CRC_BYTES) begin
               o = release_card(sdrd_pkg::ST_OK);
            end else begin
               eng_pos = pos + 10'd1;
               o = shift_out(sdrd_pkg::FILL_BYTE, 1'b1);
            end
            // CRC bytes and positions past the block are never delivered.
            if (int'(pos) < sdrd_pkg::BLOCK_BYTES && pos >= eng_offset &&
                int'(pos) < int'(eng_offset) + int'(eng_count)) begin
               o.data_valid = 1'b1;
               o.data_byte = r.rx;
               o.data_index = eng_delivered;
               eng_delivered = eng_delivered + 10'd1;
            end
         end
         default: eng_phase = sdrd_pkg::PH_IDLE;
      endcase
      return o;
   endfunction

   function automatic string show_result(input sdrd_pkg::result_type r);
      return $sformatf("tx %0b/%02h cs %0b data %0b/%02h idx %0d done %0b status %0d",
                       r.tx_valid, r.tx_byte, r.chip_select_active, r.data_valid,
                       r.data_byte, r.data_index, r.done_res, r.status_code);
   endfunction

   task automatic send_request(input read_req_type r);
      @(negedge clock);
      if (!idle_off && $urandom_range(7, 0) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(12, 1)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = r.opcode;
      req_sector_number = r.sector;
      req_window_offset = r.offset;
      req_window_count = r.count;
      req_rx_byte = r.rx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      exchange_results_due.push_back(advance_read_engine(r));
      items_sent++;
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (exchange_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input sdrd_pkg::reg_index_type idx,
                                 input logic [31:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_write_data = value;
      case (idx)
         sdrd_pkg::REG_LAST_SECTOR: cfg_last_sector = value;
         sdrd_pkg::REG_RESP_LIMIT:  cfg_resp_limit = value[15:0];
         sdrd_pkg::REG_TOKEN_LIMIT: cfg_token_limit = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // One read from start to release; the kind picks how the card answers.
   task automatic run_transfer(input xfer_kind_type xfer, input bit corner_window);
      read_req_type r;
      sdrd_pkg::phase_type seen;
      int polls;
      r.opcode = sdrd_pkg::OP_EXCHANGE;
      r.sector = $urandom;
      r.offset = 10'($urandom);
      r.count = 10'($urandom);
      r.rx = 8'($urandom);
      if ($urandom_range(9, 0) == 0) send_request(r);
      r.opcode = sdrd_pkg::OP_START;
      if (xfer == XFER_BAD_START) begin
         if (cfg_last_sector != 32'hFFFF_FFFF && $urandom_range(1, 0) == 1)
            r.sector = $urandom_range(32'hFFFF_FFFF, cfg_last_sector + 32'd1);
         else
            r.count = '0;
         send_request(r);
         return;
      end
      case ($urandom_range(3, 0))
         0: r.sector = cfg_last_sector;
         1: r.sector = '0;
         default: r.sector = (cfg_last_sector == 32'hFFFF_FFFF) ? $urandom :
                             $urandom_range(cfg_last_sector, 0);
      endcase
      if (r.count == 10'd0) r.count = 10'd1;
      if (corner_window) begin
         case ($urandom_range(3, 0))
            0: begin r.offset = 10'd0;   r.count = 10'd1023; end
            1: begin r.offset = 10'd511; r.count = 10'd1;    end
            2: begin r.offset = 10'd1023; r.count = 10'd1023; end
            default: begin r.offset = 10'd300; r.count = 10'd400; end
         endcase
      end
      send_request(r);
      seen = sdrd_pkg::PH_IDLE;
      polls = 0;
      while (eng_phase != sdrd_pkg::PH_IDLE) begin
         if (eng_phase != seen) begin
            seen = eng_phase;
            polls = $urandom_range(3, 0);
         end
         r.opcode = sdrd_pkg::OP_EXCHANGE;
         r.sector = $urandom;
         r.offset = 10'($urandom);
         r.count = 10'($urandom);
         r.rx = 8'($urandom);
         // Now and then a start request arrives mid transfer and must be ignored.
         if ($urandom_range(24, 0) == 0) begin
            r.opcode = sdrd_pkg::OP_START;
         end else begin
            case (eng_phase)
               sdrd_pkg::PH_RESP: begin
                  if (xfer == XFER_R1_TIMEOUT || polls > 0) begin
                     r.rx[7] = 1'b1;
                     polls--;
                  end else if (xfer == XFER_R1_ERROR) begin
                     r.rx = 8'($urandom_range(127, 1));
                  end else begin
                     r.rx = 8'h00;
                  end
               end
               sdrd_pkg::PH_TOKEN: begin
                  if (xfer == XFER_TOKEN_TIMEOUT || polls > 0) begin
                     r.rx = sdrd_pkg::FILL_BYTE;
                     polls--;
                  end else if (xfer == XFER_TOKEN_ERROR) begin
                     r.rx = 8'($urandom_range(253, 0));
                  end else begin
                     r.rx = sdrd_pkg::DATA_TOKEN;
                  end
               end
               default: ;
            endcase
         end
         send_request(r);
      end
   endtask

   // Random result-side stall bursts.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!idle_off && $urandom_range(9, 0) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(12, 1)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      sdrd_pkg::result_type got;
      got = '{rsp_tx_valid, rsp_tx_byte, rsp_chip_select_active, rsp_data_valid,
              rsp_data_byte, rsp_data_index, rsp_done_res,
              sdrd_pkg::status_type'(rsp_status_code)};
      if (!reset && rsp_valid && !rsp_stall) begin
         if (exchange_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: %s", show_result(got));
         end else if (got !== exchange_results_due[0]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: expected %s, actual %s",
                        show_result(exchange_results_due[0]), show_result(got));
            void'(exchange_results_due.pop_front());
         end else begin
            void'(exchange_results_due.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      logic [31:0] sector_limit;
      logic [15:0] resp_limit;
      logic [15:0] token_limit;
      int unsigned phase_base;
      int n;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_opcode = 1'b0;
      req_sector_number = '0;
      req_window_offset = '0;
      req_window_count = '0;
      req_rx_byte = '0;
      cfg_last_sector = 32'd0;
      cfg_resp_limit = 16'd16;
      cfg_token_limit = 16'd4096;
      eng_phase = sdrd_pkg::PH_IDLE;
      eng_pos = '0;
      eng_polls = 0;
      eng_address = '0;
      eng_offset = '0;
      eng_count = '0;
      eng_delivered = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_request(DIRECTED_ROWS[i].req);
         if (DIRECTED_ROWS[i].has_fixed) begin
            void'(exchange_results_due.pop_back());
            exchange_results_due.push_back(DIRECTED_ROWS[i].result);
         end
      end

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               sector_limit = 32'hFFFF_FFFF; resp_limit = 16'd1; token_limit = 16'd1;
            end
            1: begin
               sector_limit = $urandom; resp_limit = 16'hFFFF; token_limit = 16'hFFFF;
            end
            2: begin
               // A limit of zero behaves like a limit of one.
               sector_limit = '0; resp_limit = '0; token_limit = '0;
            end
            3: begin
               sector_limit = $urandom;
               resp_limit = 16'($urandom_range(8, 2));
               token_limit = 16'($urandom_range(8, 2));
            end
            default: begin
               sector_limit = 32'hFFFF_FFFF;
               resp_limit = 16'($urandom_range(30, 2));
               token_limit = 16'($urandom_range(30, 2));
            end
         endcase
         wait_until_drained();
         write_register(sdrd_pkg::REG_LAST_SECTOR, sector_limit);
         write_register(sdrd_pkg::REG_RESP_LIMIT, {16'd0, resp_limit});
         write_register(sdrd_pkg::REG_TOKEN_LIMIT, {16'd0, token_limit});
         idle_off = (p == 4);
         phase_base = items_sent;
         if (p == 4) run_transfer(XFER_FULL_READ, 1'b1);
         while (items_sent - phase_base < 90) begin
            n = $urandom_range(4, 0);
            // Timeouts are only worth running against short poll limits.
            if (n == XFER_R1_TIMEOUT && cfg_resp_limit > 40) n = XFER_R1_ERROR;
            if (n == XFER_TOKEN_TIMEOUT && cfg_token_limit > 40) n = XFER_TOKEN_ERROR;
            run_transfer(xfer_kind_type'(n), 1'b0);
            if (!idle_off && $urandom_range(5, 0) == 0) wait_until_drained();
         end
      end

      wait_until_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && exchange_results_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* sd_spi_block_read_engine.f */
rtl/sdrd_pkg.sv
rtl/sdrd_step.sv
rtl/sdrd_rsp_reg.sv
rtl/sd_spi_block_read_engine.sv
sim/testbench.sv
